// ===== src/tcce_pkg.sv =====
// Shared types, character codes and color helpers of the text console character engine.
`default_nettype none

package tcce_pkg;

  // Geometry defaults.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Result field widths.
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Escape parser phases.
  localparam logic [1:0] PH_TEXT  = 2'd0;
  localparam logic [1:0] PH_DROP  = 2'd1;
  localparam logic [1:0] PH_CODES = 2'd2;

  localparam logic [3:0] SEQ_FG_RESET = 4'd7;
  localparam logic [3:0] SEQ_BG_RESET = 4'd0;
  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam logic [2:0] TAB_STOP     = 3'd4;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
  } colors_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic write_step;
    logic scroll;
    logic report;
  } tcce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_writes;
    logic write_last;
    logic drop_write;
    logic over;
    logic slot_free;
  } tcce_status_t;

  // ANSI color index order is red, green, blue from bit 0; VGA has blue at bit 0.
  function automatic logic [2:0] ansi_to_vga(input logic [2:0] idx);
    return {idx[0], idx[1], idx[2]};
  endfunction

  function automatic colors_t apply_code(input logic [7:0] c, input colors_t cur);
    colors_t r;
    logic [7:0] off;
    r = cur;
    off = 8'd0;
    if (c inside {[8'd30:8'd37]}) begin
      off = c - 8'd30;
      r.fg = {1'b0, ansi_to_vga(off[2:0])};
    end else if (c inside {[8'd40:8'd47]}) begin
      off = c - 8'd40;
      r.bg = {1'b0, ansi_to_vga(off[2:0])};
    end else if (c inside {[8'd90:8'd97]}) begin
      off = c - 8'd90;
      r.fg = {1'b1, ansi_to_vga(off[2:0])};
    end else if (c inside {[8'd100:8'd107]}) begin
      off = c - 8'd100;
      r.bg = {1'b1, ansi_to_vga(off[2:0])};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/tcce_if.sv =====
// Valid/ready channel interfaces for character items and result items.
`default_nettype none

interface tcce_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface tcce_result_if;
  import tcce_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [INDEX_W-1:0] cell_index;
  logic [CHAR_W-1:0]  char_code;
  logic [ATTR_W-1:0]  attr;
  logic [INDEX_W-1:0] cursor_index;
  logic               last;

  modport source (output valid, output result_kind, output cell_index, output char_code,
                  output attr, output cursor_index, output last, input ready);
  modport sink (input valid, input result_kind, input cell_index, input char_code,
                input attr, input cursor_index, input last, output ready);
endinterface

`default_nettype wire

// ===== src/tcce_ctrl.sv =====
// Controller state machine that sequences the results of one character item.
`default_nettype none

module tcce_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tcce_pkg::tcce_status_t status,
  output tcce_pkg::tcce_cmd_t        cmd
);
  import tcce_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WRITE  = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = status.has_writes ? ST_WRITE : ST_SCROLL;
        end
      end
      ST_WRITE: begin
        // A write past the screen end is dropped and needs no output slot.
        if (status.slot_free || status.drop_write) begin
          cmd.write_step = 1'b1;
          if (status.write_last) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_SCROLL: begin
        if (!status.over) begin
          state_next = ST_REPORT;
        end else if (status.slot_free) begin
          cmd.scroll = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (status.slot_free) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tcce_datapath.sv =====
// Datapath: cursor, escape parser, color state and the result output register.
`default_nettype none

module tcce_datapath #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            char_byte,
  input  wire tcce_pkg::tcce_cmd_t   cmd,
  output tcce_pkg::tcce_status_t     status,
  tcce_result_if.source              result_out
);
  import tcce_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CELL_W = $clog2(CELLS + COLUMNS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int WIDE_W = (CELL_W > INDEX_W) ? CELL_W : INDEX_W;

  // Cursor kept both as a linear cell and as row and column.
  logic [CELL_W-1:0] cur_cell, cur_cell_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;

  logic [1:0]  phase, phase_next;
  logic [7:0]  accum, accum_next;
  colors_t     seq, seq_next;
  logic [7:0]  cur_attr, cur_attr_next;

  logic [2:0]  wr_count, wr_count_next;
  logic        op_bs, op_print;
  logic [7:0]  byte_q;

  logic        out_valid;
  logic        load;
  logic        is_digit;
  logic        is_text_write;
  colors_t     applied;
  logic [WIDE_W-1:0] cell_wide;

  assign is_digit      = (char_byte inside {[CH_ZERO:CH_NINE]});
  assign is_text_write = (char_byte != CH_ESC) && (char_byte != CH_NL) && (char_byte != CH_CR);
  assign applied       = apply_code(accum, seq);
  assign cell_wide     = WIDE_W'(cur_cell);

  assign status.has_writes = (phase == PH_TEXT) && is_text_write;
  assign status.write_last = (wr_count == 3'd1);
  assign status.drop_write = (row == ROW_W'(ROWS));
  assign status.over       = (row == ROW_W'(ROWS));
  assign status.slot_free  = !out_valid || result_out.ready;

  assign load = (cmd.write_step && !status.drop_write) || cmd.scroll || cmd.report;

  always_comb begin
    cur_cell_next = cur_cell;
    col_next      = col;
    row_next      = row;
    phase_next    = phase;
    accum_next    = accum;
    seq_next      = seq;
    cur_attr_next = cur_attr;
    wr_count_next = wr_count;

    if (cmd.accept) begin
      case (phase)
        PH_DROP: begin
          phase_next = PH_CODES;
        end
        PH_CODES: begin
          if (is_digit) begin
            accum_next = accum * 8'd10 + {4'd0, char_byte[3:0]};
          end else begin
            seq_next   = applied;
            accum_next = 8'd0;
            if (char_byte == CH_M) begin
              cur_attr_next = {applied.bg, applied.fg};
              phase_next    = PH_TEXT;
            end
          end
        end
        PH_TEXT: begin
          wr_count_next = 3'd1;
          if (char_byte == CH_ESC) begin
            phase_next = PH_DROP;
            accum_next = 8'd0;
            seq_next   = '{fg: SEQ_FG_RESET, bg: SEQ_BG_RESET};
          end else if (char_byte == CH_NL) begin
            cur_cell_next = cur_cell - CELL_W'(col) + CELL_W'(COLUMNS);
            col_next      = '0;
            row_next      = row + 1'b1;
          end else if (char_byte == CH_CR) begin
            cur_cell_next = cur_cell - CELL_W'(col);
            col_next      = '0;
          end else if (char_byte == CH_BS) begin
            // Clamped at the top left cell.
            if (cur_cell != '0) begin
              cur_cell_next = cur_cell - 1'b1;
              if (col == '0) begin
                col_next = COL_W'(COLUMNS - 1);
                row_next = row - 1'b1;
              end else begin
                col_next = col - 1'b1;
              end
            end
          end else if (char_byte == CH_TAB) begin
            wr_count_next = TAB_STOP - {1'b0, col[1:0]};
          end
        end
        default: begin
          phase_next = PH_TEXT;
        end
      endcase
    end

    if (cmd.write_step) begin
      wr_count_next = wr_count - 1'b1;
      if (!op_bs) begin
        cur_cell_next = cur_cell + 1'b1;
        if (col == COL_W'(COLUMNS - 1)) begin
          col_next = '0;
          row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
    end

    if (cmd.scroll) begin
      cur_cell_next = cur_cell - CELL_W'(COLUMNS);
      row_next      = row - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_cell  <= '0;
      col       <= '0;
      row       <= '0;
      phase     <= PH_TEXT;
      accum     <= 8'd0;
      seq       <= '{fg: SEQ_FG_RESET, bg: SEQ_BG_RESET};
      cur_attr  <= ATTR_RESET;
      wr_count  <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      cur_cell  <= cur_cell_next;
      col       <= col_next;
      row       <= row_next;
      phase     <= phase_next;
      accum     <= accum_next;
      seq       <= seq_next;
      cur_attr  <= cur_attr_next;
      wr_count  <= wr_count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item details captured at accept; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q   <= char_byte;
      op_bs    <= (char_byte == CH_BS);
      op_print <= (char_byte != CH_BS) && (char_byte != CH_TAB);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out.attr <= cur_attr;
      if (cmd.write_step) begin
        result_out.result_kind  <= KIND_WRITE;
        result_out.cell_index   <= cell_wide[INDEX_W-1:0];
        result_out.char_code    <= op_print ? byte_q : CH_SPACE;
        result_out.cursor_index <= '0;
        result_out.last         <= 1'b0;
      end else if (cmd.scroll) begin
        result_out.result_kind  <= KIND_SCROLL;
        result_out.cell_index   <= '0;
        result_out.char_code    <= 8'd0;
        result_out.cursor_index <= '0;
        result_out.last         <= 1'b0;
      end else begin
        result_out.result_kind  <= KIND_CURSOR;
        result_out.cell_index   <= '0;
        result_out.char_code    <= 8'd0;
        result_out.cursor_index <= cell_wide[INDEX_W-1:0];
        result_out.last         <= 1'b1;
      end
    end
  end

  assign result_out.valid = out_valid;

endmodule

`default_nettype wire

// ===== src/text_console_char_engine_core.sv =====
// Top level of the text console character engine: controller plus datapath.
//
// The block takes one raw character byte per item on char_in and gives its results
// on result_out; both are valid/ready channels, an item moving when valid and ready
// are high at a rising clock edge. Each character item yields zero to four cell
// writes (printables, backspace, tab), then a scroll result if the cursor ran past
// the screen end, and always ends with a cursor report flagged by last.
// Escape sequences (ESC, one dropped byte, decimal codes, 'm') only change the
// attribute and produce just the cursor report.
// One item is in work at a time: the controller takes the byte, then steps
// through its cell writes one at a time, then the scroll check and the cursor
// report, so that sequence sets the rate.
// A result sits in a single output register; the next item is taken while the
// cursor report of the previous one still waits there.
// When the receiver stalls, the sequence holds until the output register frees.
// Synchronous reset puts the cursor at the top left cell, sets the attribute to
// light gray on black, clears the escape parser and empties the output register.

`default_nettype none

module text_console_char_engine_core #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input wire logic       clk,
  input wire logic       rst,
  tcce_char_if.sink      char_in,
  tcce_result_if.source  result_out
);
  import tcce_pkg::*;

  tcce_cmd_t    cmd;
  tcce_status_t status;
  logic         in_ready;

  assign char_in.ready = in_ready;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .char_byte  (char_in.char_byte),
    .cmd        (cmd),
    .status     (status),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the text console character engine.
`timescale 1ns / 1ps

module tb;
  import tcce_pkg::*;

  // Screen geometry used for both the block and the predictor.
  localparam int COLS         = DEF_COLUMNS;
  localparam int LINES        = DEF_ROWS;
  localparam int SCREEN_CELLS = COLS * LINES;

  // Bytes that the package does not name but the escape sequences use.
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Number of random items and length of the long receiver hold-off.
  localparam int RANDOM_ITEMS = 135;
  localparam int HOLDOFF_LEN  = 300;
  localparam int TAIL_CYCLES  = 20;

  // One row of the stimulus script. Rows with known_report set carry the cursor
  // report that is typed in by hand; all other rows are checked by the predictor.
  typedef struct {
    logic [7:0] ch;
    bit         known_report;
    int         cursor;
    logic [7:0] attr;
  } stim_row_t;

  // One result item as the block should present it.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] cell_idx;
    logic [CHAR_W-1:0]  ch;
    logic [ATTR_W-1:0]  attr;
    logic [INDEX_W-1:0] cursor;
    logic               last;
  } console_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcce_char_if   chars ();
  tcce_result_if results ();

  text_console_char_engine_core #(
    .COLUMNS(COLS),
    .ROWS   (LINES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (chars),
    .result_out(results)
  );

  always #4 clk = ~clk;

  // The stimulus script, the results still owed by the block and the error count.
  stim_row_t       script[$];
  console_result_t pending_results[$];
  int              directed_count;
  int              accepted_count = 0;
  int              fail_count = 0;

  // Requests from the sender for a long receiver hold-off, and how many were served.
  int holdoffs_wanted = 0;
  int holdoffs_taken  = 0;
  int hold_left       = 0;
  int rx_cycle        = 0;

  // Predictor state: cursor, attribute and the escape parser.
  int         cursor_pos;
  logic [7:0] cur_attr;
  logic [1:0] parse_phase;
  logic [7:0] code_acc;
  logic [3:0] seq_fg;
  logic [3:0] seq_bg;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_console();
    cursor_pos  = 0;
    cur_attr    = ATTR_RESET;
    parse_phase = PH_TEXT;
    code_acc    = 8'd0;
    seq_fg      = SEQ_FG_RESET;
    seq_bg      = SEQ_BG_RESET;
  endtask

  task automatic owe_result(input logic [KIND_W-1:0] kind, input int cell_idx,
                            input logic [7:0] ch);
    console_result_t r;
    r.kind     = kind;
    r.cell_idx = cell_idx[INDEX_W-1:0];
    r.ch       = ch;
    r.attr     = cur_attr;
    r.cursor   = '0;
    r.last     = 1'b0;
    pending_results.push_back(r);
  endtask

  // An SGR color index counts red, green, blue from bit 0, while the attribute
  // nibble has blue in bit 0, so the three low bits are mirrored.
  function automatic logic [3:0] vga_color(input logic [7:0] code, input logic [7:0] base,
                                           input logic bright);
    logic [7:0] n;
    n = code - base;
    return {bright, n[0], n[1], n[2]};
  endfunction

  // A finished SGR code updates the colors of the sequence in progress. Zero and
  // codes outside the four color ranges leave them alone.
  task automatic sgr_apply(input logic [7:0] code);
    if (code >= 8'd30 && code <= 8'd37) begin
      seq_fg = vga_color(code, 8'd30, 1'b0);
    end else if (code >= 8'd40 && code <= 8'd47) begin
      seq_bg = vga_color(code, 8'd40, 1'b0);
    end else if (code >= 8'd90 && code <= 8'd97) begin
      seq_fg = vga_color(code, 8'd90, 1'b1);
    end else if (code >= 8'd100 && code <= 8'd107) begin
      seq_bg = vga_color(code, 8'd100, 1'b1);
    end
  endtask

  // Works out every result that one character item causes and queues them.
  task automatic console_step(input logic [7:0] b);
    int row;
    int spaces;
    row = cursor_pos / COLS;
    case (parse_phase)
      PH_DROP: begin
        parse_phase = PH_CODES;
      end
      PH_CODES: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          // Eight-bit arithmetic makes the code wrap modulo 256.
          code_acc = code_acc * 8'd10 + (b - CH_ZERO);
        end else begin
          sgr_apply(code_acc);
          code_acc = 8'd0;
          if (b == CH_M) begin
            cur_attr    = {seq_bg, seq_fg};
            parse_phase = PH_TEXT;
          end
        end
      end
      PH_TEXT: begin
        if (b == CH_ESC) begin
          parse_phase = PH_DROP;
          code_acc    = 8'd0;
          seq_fg      = SEQ_FG_RESET;
          seq_bg      = SEQ_BG_RESET;
        end else if (b == CH_NL) begin
          cursor_pos = (row + 1) * COLS;
        end else if (b == CH_CR) begin
          cursor_pos = row * COLS;
        end else if (b == CH_BS) begin
          if (cursor_pos > 0) cursor_pos--;
          owe_result(KIND_WRITE, cursor_pos, CH_SPACE);
        end else if (b == CH_TAB) begin
          spaces = int'(TAB_STOP) - ((cursor_pos % COLS) % int'(TAB_STOP));
          for (int k = 0; k < spaces; k++) begin
            // Writes past the last cell would be scrolled away, so none is made.
            if (cursor_pos < SCREEN_CELLS) owe_result(KIND_WRITE, cursor_pos, CH_SPACE);
            cursor_pos++;
          end
        end else begin
          owe_result(KIND_WRITE, cursor_pos, b);
          cursor_pos++;
        end
        if (cursor_pos >= SCREEN_CELLS) begin
          owe_result(KIND_SCROLL, 0, 8'd0);
          cursor_pos -= COLS;
        end
      end
      default: begin
        parse_phase = PH_TEXT;
      end
    endcase
    // Every item ends with the cursor report.
    owe_result(KIND_CURSOR, 0, 8'd0);
    pending_results[pending_results.size()-1].cursor = cursor_pos[INDEX_W-1:0];
    pending_results[pending_results.size()-1].last   = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus script
  // ---------------------------------------------------------------------------

  task automatic put(input logic [7:0] b, input bit known = 1'b0, input int cur = 0,
                     input logic [7:0] at = 8'h00);
    stim_row_t r;
    r.ch           = b;
    r.known_report = known;
    r.cursor       = cur;
    r.attr         = at;
    script.push_back(r);
  endtask

  task automatic put_text(input int len);
    for (int k = 0; k < len; k++) put(8'($urandom_range(8'h20, 8'h7E)));
  endtask

  // Writes a code as decimal digits, now and then with a leading zero.
  task automatic put_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 5) == 0) put(CH_ZERO);
    for (int k = 0; k < s.len(); k++) put(s[k]);
  endtask

  // Any byte that ends a digit run without closing the sequence.
  function automatic logic [7:0] pick_separator();
    logic [7:0] b;
    b = CH_SEMI;
    if ($urandom_range(0, 4) == 0) begin
      b = 8'($urandom_range(0, 255));
      while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_M) b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic int pick_code();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      case ($urandom_range(0, 3))
        0:       return 30 + $urandom_range(0, 7);
        1:       return 40 + $urandom_range(0, 7);
        2:       return 90 + $urandom_range(0, 7);
        default: return 100 + $urandom_range(0, 7);
      endcase
    end else if (sel == 5) begin
      return 0;
    end else if (sel == 6) begin
      // Just outside each color range.
      case ($urandom_range(0, 7))
        0:       return 29;
        1:       return 38;
        2:       return 39;
        3:       return 48;
        4:       return 89;
        5:       return 98;
        6:       return 99;
        default: return 108;
      endcase
    end
    // Large values exercise the modulo-256 wrap of the accumulator.
    return $urandom_range(0, 999);
  endfunction

  // ESC, the dropped byte, zero to three codes and the closing 'm'.
  task automatic put_sgr_sequence();
    int n;
    n = $urandom_range(0, 3);
    put(CH_ESC);
    put(CH_BRACKET);
    for (int k = 0; k < n; k++) begin
      if (k > 0) put(pick_separator());
      put_number(pick_code());
    end
    put(CH_M);
  endtask

  // A sequence with random junk in it, sometimes left open.
  task automatic put_broken_sequence();
    int n;
    n = $urandom_range(1, 6);
    put(CH_ESC);
    put(8'($urandom_range(0, 255)));
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0:       put(8'($urandom_range(CH_ZERO, CH_NINE)));
        1:       put(CH_SEMI);
        2:       put(CH_NUL);
        3:       put(CH_ESC);
        default: put(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 3) != 0) put(CH_M);
  endtask

  task automatic build_script();
    int sel;
    // Directed part, starting from the reset state: cursor at 0, attribute 0x07.
    put("A",    1'b1, 1,  8'h07);
    put(CH_NUL, 1'b1, 2,  8'h07);   // NUL is stored like a printable byte
    put(8'hFF,  1'b1, 3,  8'h07);
    put(CH_TAB, 1'b1, 4,  8'h07);   // one space to the next tab stop
    put(CH_TAB, 1'b1, 8,  8'h07);   // a full four spaces
    put(CH_BS,  1'b1, 7,  8'h07);
    put(CH_CR,  1'b1, 0,  8'h07);
    put(CH_BS,  1'b1, 0,  8'h07);   // backspace clamps at the first cell
    put(CH_NL,  1'b1, 80, 8'h07);
    put(CH_ESC, 1'b1, 80, 8'h07);
    put(CH_BRACKET, 1'b1, 80, 8'h07);
    put("9");
    put("7");
    put(CH_SEMI);
    put("1");
    put("0");
    put("7");
    put(CH_M,   1'b1, 80, 8'hFF);   // bright white on bright white
    put(CH_ESC);
    put("x");                       // any byte after ESC is dropped
    put("2");
    put("8");
    put("6");                       // 286 wraps to 30, black foreground
    put(CH_ESC);                    // ESC inside a sequence only ends the code
    put("4");
    put("4");
    put(CH_M,   1'b1, 80, 8'h10);   // blue background, black foreground
    directed_count = script.size();

    // Walk the cursor down to the last row so that scrolls follow.
    for (int k = 0; k < LINES; k++) begin
      put_text($urandom_range(0, 3));
      put(CH_NL);
    end

    while (script.size() - directed_count < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        put_text($urandom_range(1, 8));
      end else if (sel < 45) begin
        case ($urandom_range(0, 3))
          0:       put(CH_NL);
          1:       put(CH_CR);
          2:       put(CH_BS);
          default: put(CH_TAB);
        endcase
      end else if (sel < 55) begin
        repeat ($urandom_range(2, 6)) put(CH_TAB);
      end else if (sel < 80) begin
        put_sgr_sequence();
      end else if (sel < 90) begin
        put_broken_sequence();
      end else begin
        put(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------------

  initial begin
    int burst_left;
    int gap;
    chars.valid     = 1'b0;
    chars.char_byte = 8'h00;
    clear_console();
    build_script();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    burst_left = 0;
    for (int i = 0; i < script.size(); i++) begin
      @(negedge clk);
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          chars.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        // Now and then a long burst gives a stretch without idling.
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10);
      end
      burst_left--;
      // At the start of the random part and again halfway through, the
      // receiver holds off for a long while so that the block backs up.
      if (i == directed_count || i == directed_count + RANDOM_ITEMS / 2) begin
        holdoffs_wanted++;
      end
      chars.valid     <= 1'b1;
      chars.char_byte <= script[i].ch;
      do @(posedge clk); while (!chars.ready);
    end
    @(negedge clk);
    chars.valid <= 1'b0;

    // Drain the remaining results, then keep watching for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: a stall pattern that moves in turn through four modes, plus long hold-offs.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      results.ready <= 1'b0;
    end else if (holdoffs_taken < holdoffs_wanted) begin
      holdoffs_taken = holdoffs_taken + 1;
      hold_left = HOLDOFF_LEN - 1;
      results.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       results.ready <= 1'b1;
        1:       results.ready <= ($urandom_range(0, 2) != 0);
        2:       results.ready <= ((rx_cycle % 3) != 0);
        default: results.ready <= ((rx_cycle % 11) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted character item and checks every
  // accepted result item against the oldest one still owed.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (!rst) begin
      if (chars.valid && chars.ready) begin
        console_step(script[accepted_count].ch);
        // Rows with a hand-typed cursor report replace the predicted one.
        if (script[accepted_count].known_report) begin
          pending_results[pending_results.size()-1].cursor =
            script[accepted_count].cursor[INDEX_W-1:0];
          pending_results[pending_results.size()-1].attr = script[accepted_count].attr;
        end
        accepted_count++;
      end
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, got kind %0d cell %0d",
                   $time, results.result_kind, results.cell_index);
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind",  want.kind,     results.result_kind);
          check_field("cell_index",   want.cell_idx, results.cell_index);
          check_field("char_code",    want.ch,       results.char_code);
          check_field("attr",         want.attr,     results.attr);
          check_field("cursor_index", want.cursor,   results.cursor_index);
          check_field("last",         want.last,     results.last);
        end
      end
    end
  end

  // Run limit: far above the slowest correct run, including both hold-offs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
